FILE: src/ksk_pkg.sv
// Shared types, constants and the control-store contents for the knapsack subset search.
`default_nettype none

package ksk_pkg;

  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned CAP_W    = 20;
  localparam int unsigned BEST_W   = 20;
  localparam logic [BEST_W-1:0] VALUE_MAX = '1;

  // Program steps of the sequencer
  typedef enum logic [2:0] {
    STEP_LOAD,
    STEP_INIT,
    STEP_READ,
    STEP_ACC,
    STEP_CMP,
    STEP_EMIT
  } ksk_step_e;

  // Subset counter operations
  typedef enum logic [1:0] {
    K_HOLD,
    K_ONE,
    K_INC,
    K_CLR
  } ksk_kop_e;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NEVER,
    COND_LAST_BEAT,
    COND_DONE,
    COND_OUT_FREE
  } ksk_cond_e;

  // One control word of the program
  typedef struct packed {
    logic      in_ready;
    logic      out_load;
    logic      clr_sums;
    ksk_kop_e  k_op;
    logic      rd_en;
    logic      acc_en;
    logic      cmp_en;
    ksk_cond_e cond;
    ksk_step_e jump_to;
    ksk_step_e next_to;
  } ksk_ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic search_done;
    logic out_free;
  } ksk_status_t;

  // Control store: one word per step
  function automatic ksk_ctrl_t ksk_microcode(ksk_step_e step);
    ksk_ctrl_t w;
    w = '0;
    case (step)
      STEP_LOAD: begin
        w.in_ready = 1'b1;
        w.cond     = COND_LAST_BEAT;
        w.jump_to  = STEP_INIT;
        w.next_to  = STEP_LOAD;
      end
      STEP_INIT: begin
        w.clr_sums = 1'b1;
        w.k_op     = K_ONE;
        w.cond     = COND_DONE;
        w.jump_to  = STEP_EMIT;
        w.next_to  = STEP_READ;
      end
      STEP_READ: begin
        w.rd_en   = 1'b1;
        w.cond    = COND_NEVER;
        w.jump_to = STEP_ACC;
        w.next_to = STEP_ACC;
      end
      STEP_ACC: begin
        w.acc_en  = 1'b1;
        w.cond    = COND_NEVER;
        w.jump_to = STEP_CMP;
        w.next_to = STEP_CMP;
      end
      STEP_CMP: begin
        w.cmp_en  = 1'b1;
        w.k_op    = K_INC;
        w.cond    = COND_DONE;
        w.jump_to = STEP_EMIT;
        w.next_to = STEP_READ;
      end
      STEP_EMIT: begin
        w.out_load = 1'b1;
        w.k_op     = K_CLR;
        w.cond     = COND_OUT_FREE;
        w.jump_to  = STEP_LOAD;
        w.next_to  = STEP_EMIT;
      end
      default: begin
        w.cond    = COND_NEVER;
        w.jump_to = STEP_LOAD;
        w.next_to = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: src/ksk_sequencer.sv
// Step counter, control store lookup and conditional jump logic.
`default_nettype none

module ksk_sequencer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              last_item_i,
  input  ksk_pkg::ksk_status_t   status_i,
  output ksk_pkg::ksk_ctrl_t     ctrl_o
);
  import ksk_pkg::*;

  ksk_step_e step_q, step_d;
  logic      take_jump;

  // Decode the current step
  assign ctrl_o = ksk_microcode(step_q);

  // Evaluate the jump condition
  always_comb begin
    case (ctrl_o.cond)
      COND_NEVER:     take_jump = 1'b0;
      COND_LAST_BEAT: take_jump = ctrl_o.in_ready & in_valid_i & last_item_i;
      COND_DONE:      take_jump = status_i.search_done;
      COND_OUT_FREE:  take_jump = status_i.out_free;
      default:        take_jump = 1'b0;
    endcase
  end

  // Select the next step
  always_comb begin
    step_d = take_jump ? ctrl_o.jump_to : ctrl_o.next_to;
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/ksk_datapath.sv
// Item store, subset counter, running sums, best-value register and result register.
`default_nettype none

module ksk_datapath #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  ksk_pkg::ksk_ctrl_t                 ctrl_i,
  output ksk_pkg::ksk_status_t               status_o,
  input  wire logic                          in_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [ksk_pkg::WEIGHT_W-1:0]  item_weight_i,
  input  wire logic [ksk_pkg::VALUE_W-1:0]   item_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ksk_pkg::CAP_W-1:0]     cfg_wdata_i,
  output logic                               out_valid_o,
  output logic      [ksk_pkg::BEST_W-1:0]    best_value_o
);
  import ksk_pkg::*;

  localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned K_W   = MAX_ITEMS + 1;
  localparam int unsigned SUM_W = WEIGHT_W + CNT_W;
  localparam int unsigned CMP_W = (SUM_W > CAP_W) ? SUM_W : CAP_W;

  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [K_W-1:0]      k_q, k_d;
  logic [K_W-1:0]      k_inc;
  logic [K_W-1:0]      k_shift;
  logic [IDX_W-1:0]    lsb;
  logic                add_q;
  logic [SUM_W-1:0]    run_w_q, run_v_q, best_q;
  logic [WEIGHT_W-1:0] rd_w_q;
  logic [VALUE_W-1:0]  rd_v_q;
  logic                wr_en;
  logic                out_beat;
  logic                out_free;
  logic                out_load;
  logic                out_full_q;
  logic [BEST_W-1:0]   best_out_q;
  logic [BEST_W-1:0]   best_sat;

  logic [WEIGHT_W-1:0] weight_mem [MAX_ITEMS];
  logic [VALUE_W-1:0]  value_mem  [MAX_ITEMS];

  // Position of the lowest set bit: the item that flips in Gray order
  function automatic logic [IDX_W-1:0] lowest_bit(logic [K_W-1:0] k);
    logic [IDX_W-1:0] pos;
    pos = '0;
    for (int i = K_W - 1; i >= 0; i--) begin
      if (k[i]) pos = IDX_W'(i);
    end
    return pos;
  endfunction

  assign lsb      = lowest_bit(k_q);
  assign k_shift  = k_q >> lsb;
  assign k_inc    = k_q + K_W'(1);
  assign wr_en    = ctrl_i.in_ready & in_valid_i & (cnt_q < CNT_W'(MAX_ITEMS));
  assign out_beat = out_full_q & out_ready_i;
  assign out_free = ~out_full_q | out_ready_i;
  assign out_load = ctrl_i.out_load & out_free;

  // Last subset reached when the next count would be 2^n; result slot free
  assign status_o = '{search_done: k_inc[cnt_q], out_free: out_free};

  // Subset counter next value
  always_comb begin
    case (ctrl_i.k_op)
      K_HOLD:  k_d = k_q;
      K_ONE:   k_d = K_W'(1);
      K_INC:   k_d = k_inc;
      K_CLR:   k_d = '0;
      default: k_d = k_q;
    endcase
  end

  // Item store: write on load beats, registered read during the search
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      weight_mem[cnt_q[IDX_W-1:0]] <= item_weight_i;
      value_mem[cnt_q[IDX_W-1:0]]  <= item_value_i;
    end
    if (ctrl_i.rd_en) begin
      rd_w_q <= weight_mem[lsb];
      rd_v_q <= value_mem[lsb];
    end
  end

  // Saturate the best value to the output width
  assign best_sat = (CMP_W'(best_q) > CMP_W'(VALUE_MAX)) ? VALUE_MAX : BEST_W'(best_q);

  // Control registers, counters and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= '0;
      cnt_q      <= '0;
      k_q        <= '0;
      add_q      <= 1'b0;
      run_w_q    <= '0;
      run_v_q    <= '0;
      best_q     <= '0;
      out_full_q <= 1'b0;
      best_out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_load) begin
        cnt_q <= '0;
      end else if (wr_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      k_q <= k_d;
      // Item enters the subset when the bit above it is clear
      if (ctrl_i.rd_en) begin
        add_q <= ~k_shift[1];
      end
      if (ctrl_i.clr_sums) begin
        run_w_q <= '0;
        run_v_q <= '0;
        best_q  <= '0;
      end else begin
        if (ctrl_i.acc_en) begin
          if (add_q) begin
            run_w_q <= run_w_q + SUM_W'(rd_w_q);
            run_v_q <= run_v_q + SUM_W'(rd_v_q);
          end else begin
            run_w_q <= run_w_q - SUM_W'(rd_w_q);
            run_v_q <= run_v_q - SUM_W'(rd_v_q);
          end
        end
        if (ctrl_i.cmp_en && (CMP_W'(run_w_q) <= CMP_W'(cap_q)) && (run_v_q > best_q)) begin
          best_q <= run_v_q;
        end
      end
      // Register the result; free the slot on its beat
      if (out_load) begin
        out_full_q <= 1'b1;
        best_out_q <= best_sat;
      end else if (out_beat) begin
        out_full_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_full_q;
  assign best_value_o = best_out_q;

endmodule

`default_nettype wire

FILE: src/knapsack_subset_search_core.sv
// Top level of the exhaustive 0/1 knapsack subset search.
// Loading: one item beat per cycle while in_ready_o is high.
// Search: with n items held, the sums are cleared after the last item beat, then each subset in turn
//   is read, added or subtracted and compared, then the best value is registered as the result beat.
// The registered result keeps loading open; a finished search waits for a free result slot.
// Reset: asynchronous, active low; capacity is 0, the store is empty, loading is open.
`default_nettype none

module knapsack_subset_search_core #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ksk_pkg::WEIGHT_W-1:0]  item_weight_i,
  input  wire logic [ksk_pkg::VALUE_W-1:0]   item_value_i,
  input  wire logic                          last_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [ksk_pkg::BEST_W-1:0]    best_value_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ksk_pkg::CAP_W-1:0]     cfg_wdata_i
);
  import ksk_pkg::*;

  ksk_ctrl_t   ctrl;
  ksk_status_t status;

  // Program sequencer
  ksk_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_item_i (last_item_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // Datapath driven by the control word
  ksk_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .in_valid_i    (in_valid_i),
    .out_ready_i   (out_ready_i),
    .item_weight_i (item_weight_i),
    .item_value_i  (item_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .best_value_o  (best_value_o)
  );

  assign in_ready_o = ctrl.in_ready;

endmodule

`default_nettype wire

FILE: src/ksk_checker.sv
// Port-level checks of the knapsack search core and the bind that attaches them.
`default_nettype none

module ksk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        last_item_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [19:0] best_value_o
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_value_o))
    else $error("result changed while stalled");

  // Keep the result channel quiet in reset
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  // Close loading once the last item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_item_i |=> !in_ready_o)
    else $error("loading still open after last item");

  // Register a new result only at the end of a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while loading");

endmodule

bind knapsack_subset_search_core ksk_checker u_ksk_checker (.*);

`default_nettype wire

FILE: tb/knapsack_subset_search_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the knapsack subset search core: item sets in, best fitting value out.
module knapsack_subset_search_core_test;
  import ksk_pkg::*;

  localparam int unsigned MAX_HELD    = 16;
  localparam int unsigned ITEM_TARGET = 550;
  localparam int unsigned STALL_LIMIT = 800000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam logic [CAP_W-1:0] CAP_FULL = '1;

  // Track the item store and capacity, predict the best value of each set
  class knapsack_tracker;
    logic [WEIGHT_W-1:0] weights [MAX_HELD];
    logic [VALUE_W-1:0]  values  [MAX_HELD];
    int unsigned         held;
    logic [CAP_W-1:0]    capacity;
    logic [BEST_W-1:0]   best_due [$];
    int unsigned         errors;

    function new();
      held     = 0;
      capacity = '0;
      errors   = 0;
    endfunction

    // Walk all subsets in Gray-code order, one item in or out per step
    function logic [BEST_W-1:0] best_fitting_value();
      int unsigned run_w;
      int unsigned run_v;
      int unsigned best;
      int unsigned total;
      int unsigned b;
      int unsigned g;
      run_w = 0;
      run_v = 0;
      best  = 0;
      total = 1 << held;
      for (int unsigned k = 1; k < total; k++) begin
        b = 0;
        while (((k >> b) & 1) == 0) b++;
        g = k ^ (k >> 1);
        if ((g >> b) & 1) begin
          run_w += weights[b];
          run_v += values[b];
        end else begin
          run_w -= weights[b];
          run_v -= values[b];
        end
        if (run_w <= capacity && run_v > best) best = run_v;
      end
      if (best > VALUE_MAX) return VALUE_MAX;
      return best[BEST_W-1:0];
    endfunction

    // Store an accepted item beat; the last one closes the set
    function void take_item(logic [WEIGHT_W-1:0] w, logic [VALUE_W-1:0] v, logic last);
      if (held < MAX_HELD) begin
        weights[held] = w;
        values[held]  = v;
        held++;
      end
      if (last) begin
        best_due.push_back(best_fitting_value());
        held = 0;
      end
    endfunction

    // Compare a result beat with the oldest pending prediction
    function void check_best(logic [BEST_W-1:0] got);
      logic [BEST_W-1:0] want;
      if (best_due.size() == 0) begin
        errors++;
        $display("%0t: best_value expected none, got %0d", $time, got);
        return;
      end
      want = best_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: best_value expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [WEIGHT_W-1:0] item_weight_i;
  logic [VALUE_W-1:0]  item_value_i;
  logic                last_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [BEST_W-1:0]   best_value_o;
  logic                cfg_we_i;
  logic [CAP_W-1:0]    cfg_wdata_i;

  knapsack_tracker tracker = new();
  int unsigned     items_sent     = 0;
  int unsigned     sets_sent      = 0;
  int unsigned     results_seen   = 0;
  int unsigned     quiet_cycles   = 0;
  bit              no_idle        = 1'b0;
  bit              long_hold_done = 1'b0;

  knapsack_subset_search_core #(
    .MAX_ITEMS(MAX_HELD)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_weight_i(item_weight_i),
    .item_value_i (item_value_i),
    .last_item_i  (last_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_value_o (best_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, a few long ones, none in a no-idle phase
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample both channels at the edge and feed the tracker
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      tracker.take_item(item_weight_i, item_value_i, last_item_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_best(best_value_o);
      results_seen++;
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[knapsack_subset_search_core] ERROR");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that backs up the input
  initial begin
    int unsigned pause;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= 30) begin
        long_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      pause = pick_gap();
      if (pause > 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Offer one item beat, hold it until taken, then maybe idle
  task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                           input logic last);
    int unsigned pause;
    in_valid_i    <= 1'b1;
    item_weight_i <= w;
    item_value_i  <= v;
    last_item_i   <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (last) sets_sent++;
    pause = pick_gap();
    if (pause > 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
  endtask

  // Send one set of random items; light sets keep weights small so capacity bites
  task automatic send_set(input int unsigned n, input bit light);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(light ? WEIGHT_W'($urandom_range(0, 3000)) : WEIGHT_W'($urandom),
                VALUE_W'($urandom), i == n - 1);
    end
  endtask

  // Drop valid and hold until every set has produced its result beat
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (results_seen < sets_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write capacity with the core idle
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.capacity = c;
  endtask

  initial begin
    int unsigned phase;
    int unsigned r;
    int unsigned n;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    item_weight_i <= '0;
    item_value_i  <= '0;
    last_item_i   <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero capacity: only the zero-weight item fits
    set_capacity('0);
    send_item(16'h0000, 16'hFFFF, 1'b0);
    send_item(16'h0001, 16'h0005, 1'b1);
    // Nothing fits: only the empty subset remains
    send_item(16'hFFFF, 16'hFFFF, 1'b1);
    // Full store at maximum capacity; the extra last item is dropped
    set_capacity(CAP_FULL);
    repeat (MAX_HELD) send_item('1, '1, 1'b0);
    send_item('1, '1, 1'b1);
    send_item('0, '0, 1'b1);

    // Random phases, each with its own capacity and idling mode
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0:       set_capacity('0);
        1:       set_capacity(CAP_FULL);
        2:       set_capacity(CAP_W'($urandom));
        3:       set_capacity(CAP_W'($urandom_range(0, 20000)));
        default: set_capacity(CAP_W'($urandom_range(30000, 300000)));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      // Overfill the store once with random content
      if (phase == 2) send_set(MAX_HELD + $urandom_range(1, 3), 1'b1);
      repeat ($urandom_range(6, 14)) begin
        r = $urandom_range(0, 19);
        if (r < 14) n = $urandom_range(1, 5);
        else if (r < 19) n = $urandom_range(6, 10);
        else n = $urandom_range(11, 12);
        send_set(n, $urandom_range(0, 1));
      end
      phase++;
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.best_due.size() == 0) begin
      $display("[knapsack_subset_search_core] OK");
    end else begin
      $display("[knapsack_subset_search_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: knapsack_subset_search_core.f
src/ksk_pkg.sv
src/ksk_sequencer.sv
src/ksk_datapath.sv
src/knapsack_subset_search_core.sv
src/ksk_checker.sv
tb/knapsack_subset_search_core_test.sv
